>>> src/sdh_pkg.sv
// Package: register indexes, constants and sequencer states of the SD host block.
package sdh_pkg;

  localparam int CardAddrBits = 16;
  localparam int BufBytes = 4096;
  localparam int BufIdxBits = $clog2(BufBytes);
  localparam int NumRegs = 17;

  localparam logic [4:0] RCon    = 5'd0;
  localparam logic [4:0] RCarg   = 5'd2;
  localparam logic [4:0] RCcon   = 5'd3;
  localparam logic [4:0] RCsta   = 5'd4;
  localparam logic [4:0] RRsp0   = 5'd5;
  localparam logic [4:0] RRsp1   = 5'd6;
  localparam logic [4:0] RRsp2   = 5'd7;
  localparam logic [4:0] RRsp3   = 5'd8;
  localparam logic [4:0] RDtimer = 5'd9;
  localparam logic [4:0] RBsize  = 5'd10;
  localparam logic [4:0] RDcnt   = 5'd12;
  localparam logic [4:0] RDsta   = 5'd13;
  localparam logic [4:0] RFsta   = 5'd14;
  localparam logic [4:0] RDat    = 5'd15;

  typedef enum logic [3:0] {
    StIdle,     // waiting for an access
    StRdByte,   // card byte read issued
    StRdNext,   // card byte arrives, pack it
    StRdEnd,    // finish a data register read
    StWrByte,   // put one byte in the write buffer
    StWrEnd,    // block complete check
    StFlushRd,  // read the write buffer
    StFlushWr,  // write one byte into the card
    StDone      // result register holds the answer
  } state_e;

endpackage

>>> src/sdh_if.sv
// Handshake channel interface carrying one payload.
interface sdh_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/sd_host_interface_with_card_model.sv
// Top level of the SD host interface with its card store and write buffer.
//
//   channel  | dir | payload
//   in_ch    | in  | {command[37], reg_index[36:32], wr_word[31:0]}
//   out_ch   | out | rd_word[31:0]
//   cfg      | in  | cfg_we_i, cfg_data_i (card_present)
//
// A data register read fetches each byte through the card store read port; a data
// register write puts each byte into the write buffer, and a completing block
// write flushes each byte from the buffer into the card (a dropped block writes
// nothing).
// Reset clears the registers but the data timer, which it sets to 0x2000; the card store keeps its contents.
// The block takes no new item until its result has been transferred.
module sd_host_interface_with_card_model
  import sdh_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_data_i,
  sdh_if.sink   in_ch,
  sdh_if.source out_ch
);

  localparam logic [CardAddrBits:0] CardBytes = {1'b1, {CardAddrBits{1'b0}}};

  logic         present_q;
  logic [31:0]  rf_q [NumRegs];
  logic [31:0]  rd_addr_q, wr_addr_q;
  logic [11:0]  rd_len_q, rd_pos_q, wr_len_q;
  logic [12:0]  wr_pos_q;
  logic         multi_q;
  state_e       state_q;
  logic [31:0]  data_q, res_q;
  logic [1:0]   cnt_q;
  logic [12:0]  fl_q;

  // The card store powers up empty and is never cleared by reset.
  logic [7:0]   card_mem [2**CardAddrBits] = '{default: 8'h00};
  logic [7:0]   buf_mem [BufBytes];
  logic [7:0]   card_rd_q, buf_rd_q;

  logic [CardAddrBits-1:0] rd_caddr, fl_caddr;
  logic [32:0]  rd_end, wr_end;
  logic [11:0]  avail;
  logic [31:0]  fsta;
  logic [7:0]   wbyte;

  assign rd_caddr = CardAddrBits'(rd_addr_q + 32'(rd_pos_q));
  assign fl_caddr = CardAddrBits'(wr_addr_q + 32'(fl_q));
  assign rd_end = {1'b0, rd_addr_q} + 33'(rd_len_q);
  assign wr_end = {1'b0, wr_addr_q} + 33'(wr_len_q);
  assign avail = rd_len_q - rd_pos_q;
  assign wbyte = data_q[8*(3-cnt_q) +: 8];

  // FIFO status word built from the bytes left in the read block.
  always_comb begin
    fsta = 32'h2400;
    if (avail > 12'd63) fsta |= 32'h1000 | 32'h100 | 32'h80 | 32'h40;
    else if (avail > 12'd31) fsta |= 32'h1000 | 32'h200 | 32'h80 | 32'(avail);
    else fsta |= 32'h1000 | 32'h200 | 32'(avail);
  end

  // Card store port and write buffer port. A dropped block writes nothing.
  always_ff @(posedge clk_i) begin
    card_rd_q <= card_mem[rd_caddr];
    if (state_q == StFlushWr && fl_q < {1'b0, wr_len_q}) card_mem[fl_caddr] <= buf_rd_q;
    buf_rd_q <= buf_mem[fl_q[BufIdxBits-1:0]];
    if (state_q == StWrByte && wr_pos_q < 13'(BufBytes))
      buf_mem[wr_pos_q[BufIdxBits-1:0]] <= wbyte;
  end

  assign in_ch.ready = (state_q == StIdle);
  assign out_ch.valid = (state_q == StDone);
  assign out_ch.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) present_q <= 1'b0;
    else if (cfg_we_i) present_q <= cfg_data_i;
  end

  // Sequencer: one byte step per pass through the card store or the write buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [5:0] c;
    logic [11:0] bl;
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
      rf_q[RDtimer] <= 32'h2000;
      rd_addr_q <= '0; rd_len_q <= '0; rd_pos_q <= '0;
      wr_addr_q <= '0; wr_len_q <= '0; wr_pos_q <= '0;
      multi_q <= 1'b0; cnt_q <= '0; fl_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (in_ch.valid) begin
          data_q <= in_ch.payload[31:0];
          state_q <= StDone;
          res_q <= '0;
          cnt_q <= '0;
          if (in_ch.payload[36:32] >= 5'(NumRegs)) begin
            res_q <= in_ch.payload[37] ? 32'h0 : 32'hffffffff;
          end else if (!in_ch.payload[37]) begin
            unique case (in_ch.payload[36:32])
              RDat: if (rd_len_q > rd_pos_q) begin
                state_q <= StRdByte;
                res_q <= '0;
              end else res_q <= rf_q[RDat];
              RFsta: begin rf_q[RFsta] <= fsta; res_q <= fsta; end
              RDsta: begin
                res_q <= (rf_q[RDsta] & ~32'hf)
                       | {30'd0, 12'(wr_len_q) != wr_pos_q[11:0] || wr_pos_q[12],
                          rd_len_q != rd_pos_q};
                rf_q[RDsta] <= (rf_q[RDsta] & ~32'hf)
                       | {30'd0, 12'(wr_len_q) != wr_pos_q[11:0] || wr_pos_q[12],
                          rd_len_q != rd_pos_q};
              end
              default: res_q <= rf_q[in_ch.payload[36:32]];
            endcase
          end else begin
            unique case (in_ch.payload[36:32])
              RCon: rf_q[RCon] <= in_ch.payload[31:0] & ~32'h2;
              RCsta: rf_q[RCsta] <= rf_q[RCsta] & ~(in_ch.payload[31:0] & 32'hf00);
              RDsta: rf_q[RDsta] <= rf_q[RDsta] & ~(in_ch.payload[31:0] & 32'h3f8);
              RFsta: ;
              RDat: begin
                rf_q[RDat] <= in_ch.payload[31:0];
                if ({1'b0, wr_len_q} > wr_pos_q) state_q <= StWrByte;
              end
              RCcon: begin
                rf_q[RCcon] <= in_ch.payload[31:0];
                if (!in_ch.payload[8]) begin
                  rf_q[RCsta] <= '0;
                  rf_q[RRsp0] <= '0; rf_q[RRsp1] <= '0;
                  rf_q[RRsp2] <= '0; rf_q[RRsp3] <= '0;
                end else if (!in_ch.payload[9]) begin
                  rf_q[RCsta] <= (rf_q[RCsta] | 32'h800) & ~32'h10ff;
                end else begin
                  c = in_ch.payload[5:0];
                  bl = rf_q[RBsize][11:0];
                  rf_q[RCsta] <= ((rf_q[RCsta] | 32'h800) & ~32'h10ff) | 32'h200 | 32'(c);
                  unique case (c)
                    6'd0: ;
                    6'd1: begin
                      rf_q[RCsta] <= ((rf_q[RCsta] | 32'h800) & ~32'h10ff) | 32'h23f;
                      rf_q[RRsp0] <= 32'h80ff8000; rf_q[RRsp1] <= 32'hff000000;
                    end
                    6'd2: begin
                      rf_q[RCsta] <= ((rf_q[RCsta] | 32'h800) & ~32'h10ff) | 32'h23f;
                      rf_q[RRsp0] <= 32'h02000053; rf_q[RRsp1] <= 32'h444d3036;
                      rf_q[RRsp2] <= 32'h34011234; rf_q[RRsp3] <= 32'h567813ff;
                    end
                    6'd3: begin
                      rf_q[RRsp0] <= 32'h00000700; rf_q[RRsp1] <= 32'hff000000;
                    end
                    6'd7: begin
                      rf_q[RRsp0] <= 32'h00000900; rf_q[RRsp1] <= 32'hff000000;
                    end
                    6'd9: begin
                      rf_q[RRsp0] <= 32'h8c0f002a;
                      rf_q[RRsp1] <= 32'h0f508000 | 32'h3f | (32'd9 << 16);
                      rf_q[RRsp2] <= 32'h2dd47c1f | (32'd3 << 30) | (32'd7 << 15);
                      rf_q[RRsp3] <= 32'h8a0040ff | (32'd9 << 22);
                    end
                    6'd10: begin
                      rf_q[RRsp0] <= 32'h02000053; rf_q[RRsp1] <= 32'h444d3036;
                      rf_q[RRsp2] <= 32'h34011234; rf_q[RRsp3] <= 32'h567813ff;
                    end
                    6'd12: begin
                      multi_q <= 1'b0;
                      rf_q[RRsp0] <= 32'h00000900; rf_q[RRsp1] <= 32'hff000000;
                    end
                    6'd17, 6'd18: begin
                      if (c == 6'd18) multi_q <= 1'b1;
                      rd_addr_q <= rf_q[RCarg];
                      rd_pos_q <= '0;
                      if (!present_q
                          || {1'b0, rf_q[RCarg]} + 33'(bl) > 33'(CardBytes)) begin
                        rd_len_q <= '0;
                        rf_q[RDcnt] <= 32'h1000;
                      end else begin
                        rd_len_q <= bl;
                        rf_q[RDcnt] <= 32'h1000 | 32'(bl);
                      end
                      rf_q[RRsp0] <= 32'h00000b00; rf_q[RRsp1] <= 32'hff000000;
                      rf_q[RDsta] <= rf_q[RDsta] | 32'h210;
                    end
                    6'd24, 6'd25: begin
                      if (c == 6'd25) multi_q <= 1'b1;
                      wr_addr_q <= rf_q[RCarg];
                      wr_pos_q <= '0;
                      wr_len_q <= present_q ? bl : 12'd0;
                      rf_q[RDcnt] <= 32'h1000 | 32'(present_q ? bl : 12'd0);
                      rf_q[RRsp0] <= 32'h00000d00; rf_q[RRsp1] <= 32'hff000000;
                    end
                    default: rf_q[RCsta] <=
                        (((rf_q[RCsta] | 32'h800) & ~32'h10ff) | 32'h400);
                  endcase
                end
              end
              default: rf_q[in_ch.payload[36:32]] <= in_ch.payload[31:0];
            endcase
          end
        end
        // Read path: address settles, byte arrives, pack it.
        StRdByte: state_q <= StRdNext;
        StRdNext: begin
          res_q[8*(3-cnt_q) +: 8] <= card_rd_q;
          rd_pos_q <= rd_pos_q + 12'd1;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3 || rd_len_q <= rd_pos_q + 12'd1) state_q <= StRdEnd;
          else state_q <= StRdByte;
        end
        StRdEnd: begin
          state_q <= StDone;
          rf_q[RDat] <= res_q;
          if (rd_pos_q >= rd_len_q) begin
            rd_pos_q <= '0;
            if (multi_q) begin
              rd_addr_q <= rd_addr_q + 32'(rd_len_q);
              if (!present_q || rd_end + 33'(rd_len_q) > 33'(CardBytes)) begin
                rd_len_q <= '0;
                rf_q[RDcnt] <= '0;
              end else rf_q[RDcnt] <= 32'(rd_len_q);
              rf_q[RDsta] <= rf_q[RDsta] | 32'h210;
            end else begin
              rd_len_q <= '0;
              rf_q[RDcnt] <= '0;
            end
          end else rf_q[RDcnt] <= 32'(rd_len_q - rd_pos_q);
        end
        // Write path: one byte per cycle into the buffer.
        StWrByte: begin
          wr_pos_q <= wr_pos_q + 13'd1;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3 || {1'b0, wr_len_q} <= wr_pos_q + 13'd1) state_q <= StWrEnd;
        end
        StWrEnd: begin
          if (wr_pos_q >= {1'b0, wr_len_q}) begin
            fl_q <= '0;
            if (present_q && wr_end <= 33'(CardBytes) && wr_len_q != 12'd0)
              state_q <= StFlushRd;
            else state_q <= StFlushWr;
            if (!(present_q && wr_end <= 33'(CardBytes) && wr_len_q != 12'd0))
              fl_q <= {1'b0, wr_len_q};
          end else begin
            rf_q[RDcnt] <= 32'(wr_len_q - wr_pos_q[11:0]);
            state_q <= StDone;
          end
        end
        StFlushRd: state_q <= StFlushWr;
        StFlushWr: begin
          if (fl_q + 13'd1 < {1'b0, wr_len_q}) begin
            fl_q <= fl_q + 13'd1;
            state_q <= StFlushRd;
          end else begin
            wr_pos_q <= '0;
            if (multi_q) begin
              wr_addr_q <= wr_addr_q + 32'(wr_len_q);
              if (!present_q) wr_len_q <= '0;
              rf_q[RDcnt] <= 32'(present_q ? wr_len_q : 12'd0);
            end else begin
              wr_len_q <= '0;
              rf_q[RDcnt] <= '0;
            end
            rf_q[RDsta] <= rf_q[RDsta] | 32'h210;
            state_q <= StDone;
          end
        end
        StDone: if (out_ch.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
